// ===== design/dds_cwe_pkg.sv =====
package dds_cwe_pkg;

   localparam int MCLK_W = 26;
   localparam int NUM_W = 64;
   localparam int REM_W = MCLK_W;
   localparam int CNT_W = 5;

   localparam logic [MCLK_W-1:0] MCLK_RESET = 26'd50000000;
   localparam logic [MCLK_W-1:0] DEG_DIVISOR = 26'd360;
   localparam logic [CNT_W-1:0] DIV_LAST_STEP = 5'd31;

   localparam logic [3:0] REQ_INIT = 4'd0;
   localparam logic [3:0] REQ_ENABLE = 4'd1;
   localparam logic [3:0] REQ_DISABLE = 4'd2;
   localparam logic [3:0] REQ_FREQ_HZ = 4'd3;
   localparam logic [3:0] REQ_FREQ_CODE = 4'd4;
   localparam logic [3:0] REQ_PHASE_DEG = 4'd5;
   localparam logic [3:0] REQ_PHASE_CODE = 4'd6;
   localparam logic [3:0] REQ_SEL_FREQ = 4'd7;
   localparam logic [3:0] REQ_SEL_PHASE = 4'd8;

   localparam logic [7:0] CMD_FREQ_B3 = 8'h33;
   localparam logic [7:0] CMD_FREQ_B2 = 8'h22;
   localparam logic [7:0] CMD_FREQ_B1 = 8'h31;
   localparam logic [7:0] CMD_FREQ_B0 = 8'h20;
   localparam logic [7:0] CMD_PHASE_HI = 8'h19;
   localparam logic [7:0] CMD_PHASE_LO = 8'h08;
   localparam logic [7:0] CMD_INIT_A = 8'hF8;
   localparam logic [7:0] CMD_INIT_B = 8'h80;
   localparam logic [7:0] CMD_ENABLE = 8'hC0;
   localparam logic [7:0] CMD_DISABLE = 8'hE0;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_DIV  = 3'b010,
      ST_EMIT = 3'b100
   } state_type;

endpackage

// ===== design/dds_command_word_encoder.sv =====
// results: one per cycle while rsp_stall is low, from the cycle after acceptance; for hertz and degree
// requests only once the shared 2-bit-per-cycle restoring divider has finished
// no new request is taken until every result of the current one has been accepted;
// an ignored request type is accepted and dropped with no result
// the divider does two compare-subtract steps per cycle over a 64-bit dividend
// synchronous active-high reset: master clock 50000000, select pins low, block idle
module dds_command_word_encoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [dds_cwe_pkg::MCLK_W-1:0]   csr_data,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [3:0]                       req_type,
   input  logic [1:0]                       req_reg_index,
   input  logic [31:0]                      req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [15:0]                      rsp_spi_word,
   output logic                             rsp_word_valid,
   output logic                             rsp_freq_select_pin,
   output logic [1:0]                       rsp_phase_select_pins,
   output logic                             rsp_last
);
   import dds_cwe_pkg::*;

   state_type         state_ff, state_in;
   logic [MCLK_W-1:0] mclk_ff, mclk_in;
   logic              fpin_ff, fpin_in;
   logic [1:0]        ppin_ff, ppin_in;
   logic [3:0]        kind_ff, kind_in;
   logic [1:0]        reg_ff, reg_in;
   logic [31:0]       code_ff, code_in;
   logic [1:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [REM_W-1:0]  rem_ff, rem_in;
   logic [MCLK_W-1:0] div_ff, div_in;

   logic              req_take;
   logic              rsp_take;
   logic [REM_W:0]    t1, t2;
   logic              ge1, ge2;
   logic [REM_W-1:0]  r1, r2;
   logic [1:0]        last_idx;
   logic [7:0]        cmd_byte, dat_byte;

   assign req_stall = (state_ff != ST_IDLE);
   assign csr_ready = (state_ff == ST_IDLE);
   assign req_take = req_valid && !req_stall;
   assign rsp_valid = (state_ff == ST_EMIT);
   assign rsp_take = rsp_valid && !rsp_stall;

   // shared restoring divider, two quotient bits per cycle
   always_comb begin
      t1 = {rem_ff, num_ff[NUM_W-1]};
      ge1 = (t1 >= {1'b0, div_ff});
      r1 = ge1 ? REM_W'(t1 - {1'b0, div_ff}) : t1[REM_W-1:0];
      t2 = {r1, num_ff[NUM_W-2]};
      ge2 = (t2 >= {1'b0, div_ff});
      r2 = ge2 ? REM_W'(t2 - {1'b0, div_ff}) : t2[REM_W-1:0];
   end

   always_comb begin
      last_idx = 2'd0;
      cmd_byte = 8'h00;
      dat_byte = 8'h00;
      rsp_word_valid = 1'b1;
      unique case (kind_ff)
         REQ_INIT: begin
            last_idx = 2'd1;
            cmd_byte = (idx_ff[0]) ? CMD_INIT_B : CMD_INIT_A;
         end
         REQ_ENABLE: begin
            cmd_byte = CMD_ENABLE;
         end
         REQ_DISABLE: begin
            cmd_byte = CMD_DISABLE;
         end
         REQ_FREQ_HZ, REQ_FREQ_CODE: begin
            last_idx = 2'd3;
            unique case (idx_ff)
               2'd0: begin
                  cmd_byte = CMD_FREQ_B3;
                  dat_byte = code_ff[31:24];
               end
               2'd1: begin
                  cmd_byte = CMD_FREQ_B2;
                  dat_byte = code_ff[23:16];
               end
               2'd2: begin
                  cmd_byte = CMD_FREQ_B1;
                  dat_byte = code_ff[15:8];
               end
               default: begin
                  cmd_byte = CMD_FREQ_B0;
                  dat_byte = code_ff[7:0];
               end
            endcase
            cmd_byte = cmd_byte | {5'd0, reg_ff[0], 2'd0};
         end
         REQ_PHASE_DEG, REQ_PHASE_CODE: begin
            last_idx = 2'd1;
            if (idx_ff[0]) begin
               cmd_byte = CMD_PHASE_LO | {5'd0, reg_ff, 1'b0};
               dat_byte = code_ff[7:0];
            end else begin
               cmd_byte = CMD_PHASE_HI | {5'd0, reg_ff, 1'b0};
               dat_byte = {4'd0, code_ff[11:8]};
            end
         end
         default: begin
            rsp_word_valid = 1'b0;
         end
      endcase
   end

   assign rsp_spi_word = {cmd_byte, dat_byte};
   assign rsp_last = (idx_ff == last_idx);
   assign rsp_freq_select_pin = fpin_ff;
   assign rsp_phase_select_pins = ppin_ff;

   always_comb begin
      state_in = state_ff;
      mclk_in = mclk_ff;
      fpin_in = fpin_ff;
      ppin_in = ppin_ff;
      kind_in = kind_ff;
      reg_in = reg_ff;
      code_in = code_ff;
      idx_in = idx_ff;
      cnt_in = cnt_ff;
      num_in = num_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (csr_valid && csr_ready) begin
         mclk_in = csr_data;
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               kind_in = req_type;
               reg_in = req_reg_index;
               code_in = req_value;
               idx_in = 2'd0;
               cnt_in = '0;
               rem_in = '0;
               state_in = ST_EMIT;
               unique case (req_type)
                  REQ_INIT: begin
                     fpin_in = 1'b0;
                     ppin_in = 2'd0;
                  end
                  REQ_FREQ_HZ: begin
                     num_in = {req_value, 32'd0};
                     div_in = (mclk_ff == '0) ? MCLK_W'(1) : mclk_ff;
                     state_in = ST_DIV;
                  end
                  REQ_PHASE_DEG: begin
                     num_in = {20'd0, req_value, 12'd0};
                     div_in = DEG_DIVISOR;
                     state_in = ST_DIV;
                  end
                  REQ_SEL_FREQ: begin
                     fpin_in = req_reg_index[0];
                  end
                  REQ_SEL_PHASE: begin
                     ppin_in = req_reg_index;
                  end
                  REQ_ENABLE, REQ_DISABLE, REQ_FREQ_CODE, REQ_PHASE_CODE: begin
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_DIV: begin
            num_in = {num_ff[NUM_W-3:0], ge1, ge2};
            rem_in = r2;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == DIV_LAST_STEP) begin
               code_in = {num_ff[29:0], ge1, ge2};
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (rsp_take) begin
               if (rsp_last) begin
                  state_in = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         mclk_ff <= MCLK_RESET;
         fpin_ff <= 1'b0;
         ppin_ff <= 2'd0;
         idx_ff <= 2'd0;
         cnt_ff <= '0;
      end else begin
         state_ff <= state_in;
         mclk_ff <= mclk_in;
         fpin_ff <= fpin_in;
         ppin_ff <= ppin_in;
         idx_ff <= idx_in;
         cnt_ff <= cnt_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      reg_ff <= reg_in;
      code_ff <= code_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   a_no_accept_while_emitting: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while results pending");

   a_idle_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_take && rsp_last) |=> !rsp_valid)
      else $error("result shown after final transaction");

   a_pin_only_result: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word_valid) |-> (rsp_last && rsp_spi_word == 16'd0))
      else $error("pin-only result malformed");

   a_divider_runs: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff != DIV_LAST_STEP) |=> (state_ff == ST_DIV))
      else $error("divider left early");

   a_divider_ends: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV && cnt_ff == DIV_LAST_STEP) |=> rsp_valid)
      else $error("divider did not hand over");

endmodule
